[rtl/word_memory_with_mapped_uart_core_defines.svh]
// Assertion macros shared by the word memory with mapped UART design.
`ifndef WORD_MEMORY_WITH_MAPPED_UART_CORE_DEFINES_SVH
`define WORD_MEMORY_WITH_MAPPED_UART_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define WMU_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmu: implication check failed");

// Check that a condition implies another in the next cycle.
`define WMU_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmu: next-cycle check failed");

`endif

[rtl/wmu_pkg.sv]
// Constants and types for the word memory with mapped UART.
package wmu_pkg;

    localparam int WORD_BITS   = 16;
    localparam int CHIP_WORDS  = 1024;
    localparam int TOTAL_WORDS = 4 * CHIP_WORDS;
    localparam int ADDR_BITS   = $clog2(TOTAL_WORDS);
    localparam int CHAR_BITS   = 8;
    localparam int SUB_BITS    = 3;

    // UART register addresses at the top of the last chip
    localparam logic [ADDR_BITS-1:0] RX_BUF  = ADDR_BITS'(TOTAL_WORDS - 4);
    localparam logic [ADDR_BITS-1:0] RX_STAT = ADDR_BITS'(TOTAL_WORDS - 3);
    localparam logic [ADDR_BITS-1:0] TX_BUF  = ADDR_BITS'(TOTAL_WORDS - 2);
    localparam logic [ADDR_BITS-1:0] TX_STAT = ADDR_BITS'(TOTAL_WORDS - 1);

    // Access kind bits
    localparam int KIND_RD_BIT = 0;
    localparam int KIND_WR_BIT = 1;

    // Machine subcycles with special meaning
    localparam logic [SUB_BITS-1:0] SUB_FIRST  = 3'd1;
    localparam logic [SUB_BITS-1:0] SUB_FOURTH = 3'd4;

    // Status word bit positions
    localparam int BIT_EN   = 3;
    localparam int BIT_RDY  = 1;
    localparam int BIT_DONE = 0;

    // Poll modes
    localparam logic [1:0] POLL_OFF      = 2'd0;
    localparam logic [1:0] POLL_ON       = 2'd1;
    localparam logic [1:0] POLL_CONSUMED = 2'd2;

    // Receive read count values
    localparam logic [1:0] RX_CNT_FIRE = 2'd2;
    localparam logic [1:0] RX_CNT_MAX  = 2'd3;

    localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};

    // Receive status flags
    typedef struct packed {
        logic en;
        logic rdy;
        logic done;
    } rx_stat_t;

    // Request to the word store
    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } ram_req_t;

endpackage

[rtl/wmu_word_ram.sv]
// Word store with a registered read port and a fill sweep after reset.
module wmu_word_ram
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wmu_pkg::ram_req_t             req,
    output logic [wmu_pkg::WORD_BITS-1:0] rdata,
    output logic                          clearing
);

    logic [wmu_pkg::WORD_BITS-1:0] mem [wmu_pkg::TOTAL_WORDS];
    logic [wmu_pkg::WORD_BITS-1:0] rdata_reg;
    logic [wmu_pkg::ADDR_BITS-1:0] clr_cnt_reg;
    logic [wmu_pkg::ADDR_BITS-1:0] clr_cnt_next;
    logic                          clearing_reg;
    logic                          clearing_next;

    // Advance the fill sweep until the last word is written
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == wmu_pkg::ADDR_BITS'(wmu_pkg::TOTAL_WORDS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    // Write port: fill value during the sweep, else the request
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= wmu_pkg::WORD_ONES;
        end
        else if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port: hold data between reads
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

[rtl/word_memory_with_mapped_uart_core.sv]
// Word memory with UART registers at the top four addresses.
// Path: an accepted item is held in the input stage registers, then loads the result
// registers when the result stage frees up, and is taken from those.
// Throughput: one item per cycle while the result side is not stalled; the word
// store's single read port and its write-to-read forwarding path set that figure.
// Reset: the UART registers, read count and poll mode clear at once; a fill
// sweep then writes all 4096 words with ones, and no item is taken until it ends.
module word_memory_with_mapped_uart_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[11:0], write_data[27:12], subcycle[30:28], rx_arrived[31], rx_char[39:32]
    input  logic [39:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[15:0], tx_char[23:16], poll_mode[25:24], zero fill [31:26]
    output logic [31:0] m_axis_tdata,
    // tx_valid[0]
    output logic [0:0]  m_axis_tuser
);

    `include "word_memory_with_mapped_uart_core_defines.svh"

    localparam int WB = wmu_pkg::WORD_BITS;
    localparam int AB = wmu_pkg::ADDR_BITS;
    localparam int CB = wmu_pkg::CHAR_BITS;
    localparam int SB = wmu_pkg::SUB_BITS;

    // Input stage
    logic          s1_valid_reg;
    logic [1:0]    s1_kind_reg;
    logic [AB-1:0] s1_addr_reg;
    logic [WB-1:0] s1_wdata_reg;
    logic [SB-1:0] s1_sub_reg;
    logic          s1_arr_reg;
    logic [CB-1:0] s1_char_reg;
    logic          fwd_valid_reg;
    logic [WB-1:0] fwd_data_reg;

    // Result stage
    logic          out_valid_reg;
    logic [WB-1:0] out_rdata_reg;
    logic          out_txv_reg;
    logic [CB-1:0] out_txc_reg;
    logic [1:0]    out_poll_reg;

    // Block state
    logic [1:0]        rx_cnt_reg;
    logic [1:0]        rx_cnt_next;
    logic [1:0]        poll_reg;
    logic [1:0]        poll_next;
    wmu_pkg::rx_stat_t rx_stat_reg;
    wmu_pkg::rx_stat_t rx_stat_next;
    logic [CB-1:0]     rx_buf_reg;
    logic [CB-1:0]     rx_buf_next;
    logic [WB-1:0]     tx_buf_reg;
    logic [WB-1:0]     tx_buf_next;
    logic              tx_on_reg;
    logic              tx_on_next;

    wmu_pkg::ram_req_t ram_req;
    logic [WB-1:0]     ram_rdata;
    logic              clearing;

    logic              accept;
    logic              fire;
    logic              is_read;
    logic              is_write;
    logic              is_uart;
    logic              ram_write;
    logic [WB-1:0]     stored_word;
    wmu_pkg::rx_stat_t rx_stat_arr;
    logic [1:0]        cnt_inc;
    logic              consume;
    logic [WB-1:0]     rd_word;
    logic              txv;
    logic [WB-1:0]     res_rdata;

    // Handshake: the input stage moves on when the result stage frees up
    assign fire          = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clearing && (!s1_valid_reg || fire);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode the item in the input stage
    assign is_read  = s1_kind_reg[wmu_pkg::KIND_RD_BIT];
    assign is_write = s1_kind_reg[wmu_pkg::KIND_WR_BIT] && !is_read;
    assign is_uart  = (s1_addr_reg == wmu_pkg::RX_BUF) || (s1_addr_reg == wmu_pkg::RX_STAT) ||
                      (s1_addr_reg == wmu_pkg::TX_BUF) || (s1_addr_reg == wmu_pkg::TX_STAT);
    assign ram_write   = is_write && !is_uart;
    assign stored_word = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    // Word store access
    always_comb
    begin
        ram_req.we    = fire && ram_write;
        ram_req.waddr = s1_addr_reg;
        ram_req.wdata = s1_wdata_reg;
        ram_req.re    = accept;
        ram_req.raddr = s_axis_tdata[AB-1:0];
    end

    wmu_word_ram u_ram
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ram_req),
        .rdata    (ram_rdata),
        .clearing (clearing)
    );

    // UART register update and read selection
    always_comb
    begin
        rx_stat_arr = rx_stat_reg;
        if (s1_arr_reg)
        begin
            rx_stat_arr.rdy = 1'b1;
        end

        cnt_inc = rx_cnt_reg;
        if (s1_sub_reg == wmu_pkg::SUB_FOURTH && rx_cnt_reg != wmu_pkg::RX_CNT_MAX)
        begin
            cnt_inc = rx_cnt_reg + 2'd1;
        end

        consume = is_read && (s1_addr_reg == wmu_pkg::RX_BUF) &&
                  (cnt_inc == wmu_pkg::RX_CNT_FIRE) && rx_stat_arr.en && rx_stat_arr.rdy;

        rx_cnt_next  = rx_cnt_reg;
        poll_next    = poll_reg;
        rx_stat_next = rx_stat_arr;
        rx_buf_next  = rx_buf_reg;
        tx_buf_next  = tx_buf_reg;
        tx_on_next   = tx_on_reg;
        txv          = 1'b0;

        if (is_read && (s1_addr_reg == wmu_pkg::RX_BUF))
        begin
            rx_cnt_next = cnt_inc;
        end
        if (consume)
        begin
            rx_buf_next       = s1_char_reg;
            rx_stat_next.rdy  = 1'b0;
            rx_stat_next.done = 1'b1;
            poll_next         = wmu_pkg::POLL_CONSUMED;
            rx_cnt_next       = '0;
        end

        if (is_write)
        begin
            if (s1_addr_reg == wmu_pkg::RX_STAT && s1_sub_reg == wmu_pkg::SUB_FOURTH)
            begin
                if (s1_wdata_reg[wmu_pkg::BIT_EN])
                begin
                    rx_stat_next = '{en: 1'b1, rdy: 1'b0, done: 1'b1};
                    poll_next    = (poll_reg != wmu_pkg::POLL_OFF) ? wmu_pkg::POLL_CONSUMED
                                                                   : wmu_pkg::POLL_ON;
                end
                else
                begin
                    rx_stat_next = '{en: 1'b0, rdy: 1'b0, done: 1'b0};
                    poll_next    = wmu_pkg::POLL_OFF;
                end
            end
            else if (s1_addr_reg == wmu_pkg::TX_BUF && s1_sub_reg == wmu_pkg::SUB_FIRST &&
                     tx_on_reg)
            begin
                tx_buf_next = s1_wdata_reg;
                txv         = 1'b1;
            end
            else if (s1_addr_reg == wmu_pkg::TX_STAT)
            begin
                tx_on_next = s1_wdata_reg[wmu_pkg::BIT_EN];
            end
        end

        // Select the word that a read returns, after this item's updates
        if (s1_addr_reg == wmu_pkg::RX_BUF)
        begin
            rd_word = {{(WB-CB){1'b0}}, rx_buf_next};
        end
        else if (s1_addr_reg == wmu_pkg::RX_STAT)
        begin
            rd_word = '0;
            rd_word[wmu_pkg::BIT_EN]   = rx_stat_next.en;
            rd_word[wmu_pkg::BIT_RDY]  = rx_stat_next.rdy;
            rd_word[wmu_pkg::BIT_DONE] = rx_stat_next.done;
        end
        else if (s1_addr_reg == wmu_pkg::TX_BUF)
        begin
            rd_word = tx_buf_reg;
        end
        else if (s1_addr_reg == wmu_pkg::TX_STAT)
        begin
            rd_word = '0;
            rd_word[wmu_pkg::BIT_EN]  = tx_on_reg;
            rd_word[wmu_pkg::BIT_RDY] = tx_on_reg;
        end
        else
        begin
            rd_word = stored_word;
        end

        res_rdata = is_read ? rd_word : '0;
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rx_cnt_reg    <= '0;
            poll_reg      <= wmu_pkg::POLL_OFF;
            rx_stat_reg   <= '{en: 1'b0, rdy: 1'b0, done: 1'b0};
            rx_buf_reg    <= '0;
            tx_buf_reg    <= '0;
            tx_on_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                rx_cnt_reg  <= rx_cnt_next;
                poll_reg    <= poll_next;
                rx_stat_reg <= rx_stat_next;
                rx_buf_reg  <= rx_buf_next;
                tx_buf_reg  <= tx_buf_next;
                tx_on_reg   <= tx_on_next;
            end
        end
    end

    // Payload: capture the item and forward a same-address store write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= s_axis_tuser;
            s1_addr_reg   <= s_axis_tdata[11:0];
            s1_wdata_reg  <= s_axis_tdata[27:12];
            s1_sub_reg    <= s_axis_tdata[30:28];
            s1_arr_reg    <= s_axis_tdata[31];
            s1_char_reg   <= s_axis_tdata[39:32];
            fwd_valid_reg <= fire && ram_write && (s1_addr_reg == s_axis_tdata[AB-1:0]);
            fwd_data_reg  <= s1_wdata_reg;
        end
        if (fire)
        begin
            out_rdata_reg <= res_rdata;
            out_txv_reg   <= txv;
            out_txc_reg   <= txv ? s1_wdata_reg[CB-1:0] : '0;
            out_poll_reg  <= poll_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_poll_reg, out_txc_reg, out_rdata_reg};
    assign m_axis_tuser  = out_txv_reg;

    // Checks
    `WMU_ASSERT_IMP(a_no_accept_in_sweep, clearing, !s_axis_tready && !fire)
    `WMU_ASSERT_IMP(a_txc_zero_when_idle, out_valid_reg && !out_txv_reg, out_txc_reg == '0)
    `WMU_ASSERT_IMP(a_poll_in_range, out_valid_reg, out_poll_reg != 2'd3)
    `WMU_ASSERT_NXT(a_consume_clears_count, fire && consume, rx_cnt_reg == '0 &&
                    poll_reg == wmu_pkg::POLL_CONSUMED)

endmodule

[bench/tb_word_memory_with_mapped_uart_core.sv]
// Self-checking testbench for the word memory with memory-mapped UART registers.
module tb_word_memory_with_mapped_uart_core;

    timeunit 1ns;
    timeprecision 1ps;

    import wmu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          DRAIN_CYCLES = 16;

    localparam logic [WORD_BITS-1:0] EN_MASK    = WORD_BITS'(1) << BIT_EN;
    localparam logic [WORD_BITS-1:0] RDY_MASK   = WORD_BITS'(1) << BIT_RDY;
    localparam logic [WORD_BITS-1:0] DONE_MASK  = WORD_BITS'(1) << BIT_DONE;
    localparam logic [WORD_BITS-1:0] RX_ENABLED = EN_MASK | DONE_MASK;
    localparam logic [WORD_BITS-1:0] TX_ENABLED = EN_MASK | RDY_MASK;

    // Out-of-range subcycles, neither first nor fourth
    localparam logic [SUB_BITS-1:0] SUB_BELOW = 3'd0;
    localparam logic [SUB_BITS-1:0] SUB_ABOVE = 3'd7;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2,
        ACC_BOTH  = 2'd3
    } access_kind_e;

    typedef struct packed {
        access_kind_e         kind;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] data;
        logic [SUB_BITS-1:0]  sub;
        logic                 arrived;
        logic [CHAR_BITS-1:0] ch;
    } uart_access_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic                 tx_valid;
        logic [CHAR_BITS-1:0] tx_char;
        logic [1:0]           poll_mode;
    } uart_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Predicted block state
    logic [WORD_BITS-1:0] word_image [TOTAL_WORDS];
    logic [1:0]           rx_reads;
    logic [1:0]           poll_now;

    uart_result_t pending_results [$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    int           burst_left = 0;
    bit           sender_steady = 1'b0;

    // Receiver stall control
    int       hold_request = 0;
    int       hold_left = 0;
    int       style_left = 0;
    int       stall_style = 0;
    logic [7:0] stall_pattern = 8'hFF;
    logic [2:0] pattern_phase = '0;

    int unsigned cycle_count = 0;

    word_memory_with_mapped_uart_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Apply one access to the predicted state and return what the block should answer
    function automatic uart_result_t predict_access(input uart_access_t a);
        uart_result_t r;
        logic [1:0]   kind_bits;
        r = '0;
        kind_bits = a.kind;
        // A character arrival lands before the access itself
        if (a.arrived)
            word_image[RX_STAT] = word_image[RX_STAT] | RDY_MASK;
        if (kind_bits[KIND_RD_BIT])
        begin
            if (a.addr == RX_BUF)
            begin
                if (a.sub == SUB_FOURTH && rx_reads != RX_CNT_MAX)
                    rx_reads = rx_reads + 2'd1;
                if (rx_reads == RX_CNT_FIRE && word_image[RX_STAT][BIT_EN] &&
                    word_image[RX_STAT][BIT_RDY])
                begin
                    word_image[RX_BUF]  = {{(WORD_BITS - CHAR_BITS){1'b0}}, a.ch};
                    word_image[RX_STAT] = (word_image[RX_STAT] & ~RDY_MASK) | DONE_MASK;
                    poll_now = POLL_CONSUMED;
                    rx_reads = '0;
                end
            end
            r.read_data = word_image[a.addr];
        end
        else if (kind_bits[KIND_WR_BIT])
        begin
            case (a.addr)
                RX_BUF: ; // writes to the receive buffer are dropped
                RX_STAT:
                begin
                    if (a.sub == SUB_FOURTH)
                    begin
                        if (a.data[BIT_EN])
                        begin
                            word_image[RX_STAT] = RX_ENABLED;
                            poll_now = (poll_now != POLL_OFF) ? POLL_CONSUMED : POLL_ON;
                        end
                        else
                        begin
                            word_image[RX_STAT] = '0;
                            poll_now = POLL_OFF;
                        end
                    end
                end
                TX_BUF:
                begin
                    if (a.sub == SUB_FIRST && word_image[TX_STAT][BIT_EN] &&
                        word_image[TX_STAT][BIT_RDY])
                    begin
                        word_image[TX_BUF]  = a.data;
                        r.tx_valid          = 1'b1;
                        r.tx_char           = a.data[CHAR_BITS-1:0];
                        word_image[TX_STAT] = (word_image[TX_STAT] | RDY_MASK) & ~DONE_MASK;
                    end
                end
                TX_STAT: word_image[TX_STAT] = a.data[BIT_EN] ? TX_ENABLED : '0;
                default: word_image[a.addr] = a.data;
            endcase
        end
        r.poll_mode = poll_now;
        return r;
    endfunction

    function automatic uart_access_t make_access(input access_kind_e kind,
                                                 input logic [ADDR_BITS-1:0] addr,
                                                 input logic [WORD_BITS-1:0] data,
                                                 input logic [SUB_BITS-1:0] sub,
                                                 input logic arrived = 1'b0,
                                                 input logic [CHAR_BITS-1:0] ch = '0);
        uart_access_t a;
        a.kind    = kind;
        a.addr    = addr;
        a.data    = data;
        a.sub     = sub;
        a.arrived = arrived;
        a.ch      = ch;
        return a;
    endfunction

    // Random access that never makes a fourth-subcycle receive read or receive status write
    function automatic uart_access_t random_noise();
        uart_access_t a;
        int           pick;
        pick = $urandom_range(0, 11);
        a.kind = (pick < 2) ? ACC_NONE : ((pick < 7) ? ACC_READ : ACC_WRITE);
        case ($urandom_range(0, 5))
            0, 1:    a.addr = ADDR_BITS'(RX_BUF + $urandom_range(0, 3));
            2:       a.addr = ADDR_BITS'($urandom());
            default: a.addr = {2'($urandom_range(0, 3)),
                               ($urandom_range(0, 1) ? 10'($urandom_range(0, 7))
                                                     : 10'(10'h3F8 + $urandom_range(0, 7)))};
        endcase
        a.data    = WORD_BITS'($urandom());
        a.sub     = SUB_BITS'($urandom_range(1, 4));
        a.arrived = ($urandom_range(0, 7) == 0);
        a.ch      = CHAR_BITS'($urandom());
        // Favor transmit writes that actually go out
        if (a.kind == ACC_WRITE && a.addr == TX_BUF && $urandom_range(0, 2) != 0)
            a.sub = SUB_FIRST;
        if (a.kind == ACC_WRITE && a.addr == TX_STAT && $urandom_range(0, 3) != 0)
            a.data[BIT_EN] = 1'b1;
        // Keep the receive count and status under the control of the receive exchanges
        if (a.kind == ACC_READ && a.addr == RX_BUF && a.sub == SUB_FOURTH)
            a.sub = SUB_BITS'($urandom_range(1, 3));
        if (a.kind == ACC_WRITE && a.addr == RX_STAT && a.sub == SUB_FOURTH)
            a.sub = SUB_BITS'($urandom_range(1, 3));
        return a;
    endfunction

    // Offer one item in bursts with random gaps; predict it once it is taken
    task automatic send_access(input uart_access_t a);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (!sender_steady && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a.ch, a.arrived, a.sub, a.data, a.addr};
        s_axis_tuser  <= a.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_access(a));
        items_sent++;
    endtask

    // One complete character pickup: enable, two fourth-subcycle reads, pickup
    task automatic receive_exchange();
        logic arrived_now;
        if (!word_image[RX_STAT][BIT_EN] || $urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 2) == 0)
                send_access(make_access(ACC_WRITE, RX_STAT,
                                        WORD_BITS'($urandom()) & ~EN_MASK, SUB_FOURTH));
            send_access(make_access(ACC_WRITE, RX_STAT,
                                    WORD_BITS'($urandom()) | EN_MASK, SUB_FOURTH));
        end
        repeat ($urandom_range(0, 3)) send_access(random_noise());
        send_access(make_access(ACC_READ, RX_BUF, WORD_BITS'($urandom()), SUB_FOURTH,
                                1'($urandom_range(0, 1)), CHAR_BITS'($urandom())));
        repeat ($urandom_range(0, 3)) send_access(random_noise());
        arrived_now = ($urandom_range(0, 3) != 0);
        send_access(make_access(ACC_READ, RX_BUF, WORD_BITS'($urandom()), SUB_FOURTH,
                                arrived_now, CHAR_BITS'($urandom())));
        // Without a character the count waits at its firing value; a late arrival picks up
        if (!arrived_now)
            send_access(make_access(ACC_READ, RX_BUF, WORD_BITS'($urandom()),
                                    SUB_BITS'($urandom_range(1, 3)), 1'b1,
                                    CHAR_BITS'($urandom())));
    endtask

    task automatic run_mixed_traffic(input int item_total);
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < item_total)
        begin
            if ($urandom_range(0, 2) == 0)
                receive_exchange();
            else
                repeat ($urandom_range(1, 6)) send_access(random_noise());
        end
    endtask

    task automatic test_plain_words();
        send_access(make_access(ACC_WRITE, 12'h000, 16'h0000, SUB_FIRST));
        send_access(make_access(ACC_WRITE, 12'hFFB, 16'h8001, SUB_BELOW));
        send_access(make_access(ACC_READ,  12'h000, 16'hFFFF, SUB_ABOVE));
        send_access(make_access(ACC_READ,  12'hFFB, 16'h0000, 3'd2));
        send_access(make_access(ACC_NONE,  12'h000, 16'h5A5A, 3'd3));
        // read wins when both kind bits are set
        send_access(make_access(ACC_BOTH,  12'h000, 16'hFFFF, SUB_FOURTH));
        send_access(make_access(ACC_WRITE, RX_STAT, 16'hFFFF, SUB_FIRST));
        send_access(make_access(ACC_WRITE, RX_BUF,  16'h1234, SUB_FOURTH));
    endtask

    task automatic test_receive_path();
        send_access(make_access(ACC_WRITE, RX_STAT, EN_MASK, SUB_FOURTH));
        send_access(make_access(ACC_READ,  RX_STAT, 16'h0000, 3'd2));
        send_access(make_access(ACC_READ,  RX_BUF,  16'h0000, SUB_FOURTH, 1'b1, 8'hA5));
        send_access(make_access(ACC_READ,  RX_BUF,  16'h0000, SUB_FOURTH, 1'b0, 8'hFF));
        // enable again while polling: mode goes to consumed
        send_access(make_access(ACC_WRITE, RX_STAT, 16'hFFFF, SUB_FOURTH));
        // count reaches its firing value with no character waiting
        send_access(make_access(ACC_READ,  RX_BUF,  16'h0000, SUB_FOURTH, 1'b0, 8'h11));
        send_access(make_access(ACC_READ,  RX_BUF,  16'h0000, SUB_FOURTH, 1'b0, 8'h22));
        send_access(make_access(ACC_READ,  RX_BUF,  16'h0000, 3'd2, 1'b1, 8'h00));
        send_access(make_access(ACC_WRITE, RX_STAT, 16'hFFF7, SUB_FOURTH));
        send_access(make_access(ACC_WRITE, RX_STAT, EN_MASK, SUB_FOURTH, 1'b1, 8'h7E));
    endtask

    task automatic test_transmit_path();
        send_access(make_access(ACC_WRITE, TX_BUF,  16'h1234, SUB_FIRST));
        send_access(make_access(ACC_WRITE, TX_STAT, EN_MASK, 3'd3));
        send_access(make_access(ACC_WRITE, TX_BUF,  16'hABFF, SUB_FIRST));
        send_access(make_access(ACC_WRITE, TX_BUF,  16'h5500, 3'd2));
        send_access(make_access(ACC_READ,  TX_BUF,  16'h0000, SUB_FIRST));
    endtask

    // Hold the result side for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_request  = 300;
        sender_steady = 1'b1;
        run_mixed_traffic(60);
        sender_steady = 1'b0;
    endtask

    // Drive the read count to its ceiling, after which no character is picked up
    task automatic test_receive_saturation();
        send_access(make_access(ACC_WRITE, RX_STAT, EN_MASK, SUB_FOURTH));
        repeat (3) send_access(make_access(ACC_READ, RX_BUF, 16'h0000, SUB_FOURTH));
        send_access(make_access(ACC_READ, RX_BUF, 16'h0000, SUB_FOURTH, 1'b1, 8'h3C));
    endtask

    task automatic check_field(input string name, input logic [WORD_BITS-1:0] want,
                               input logic [WORD_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result taken with the oldest prediction
    always @(posedge clk)
    begin
        uart_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: tdata 0x%0h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_data", want.read_data, m_axis_tdata[15:0]);
                check_field("tx_valid",  want.tx_valid,  m_axis_tuser[0]);
                check_field("tx_char",   want.tx_char,   m_axis_tdata[23:16]);
                check_field("poll_mode", want.poll_mode, m_axis_tdata[25:24]);
            end
        end
    end

    // Receiver: rotate between always ready, a fixed pattern and random stalls
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (style_left == 0)
        begin
            stall_style   = $urandom_range(0, 2);
            style_left    = $urandom_range(20, 200);
            stall_pattern = 8'($urandom()) | 8'h01;
        end
        style_left--;
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (stall_style)
                0: m_axis_tready <= 1'b1;
                1:
                begin
                    m_axis_tready <= stall_pattern[pattern_phase];
                    pattern_phase = pattern_phase + 3'd1;
                end
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        // Predicted state right after reset
        foreach (word_image[i])
            word_image[i] = WORD_ONES;
        word_image[RX_BUF]  = '0;
        word_image[RX_STAT] = '0;
        word_image[TX_BUF]  = '0;
        word_image[TX_STAT] = '0;
        rx_reads = '0;
        poll_now = POLL_OFF;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_plain_words();
        test_receive_path();
        test_transmit_path();
        run_mixed_traffic(500);
        test_backpressure();
        run_mixed_traffic(500);
        test_receive_saturation();
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
